// ----- hdl/dcse_pkg.sv -----
// Shared types and constants of the DER certificate signature extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcse_pkg;

  localparam int DEF_MAX_CERT_BYTES    = 4096;
  localparam int DEF_MAX_LENGTH_OCTETS = 4;
  localparam int DEF_QUEUE_DEPTH       = 2;

  localparam int SIG_LIMIT_W = 13;
  localparam logic [SIG_LIMIT_W-1:0] SIG_LIMIT_RESET = 13'd1024;

  localparam logic [7:0] TAG_SEQUENCE     = 8'h30;
  localparam logic [7:0] TAG_VERSION_MASK = 8'ha0;
  localparam logic [7:0] LEN_LONG_FORM    = 8'h80;
  localparam logic [6:0] LEN_COUNT_MASK   = 7'h7f;

  localparam logic [2:0] ST_DATA       = 3'd0;
  localparam logic [2:0] ST_NOT_DER    = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ST_SIG_LONG   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd5;
  localparam logic [2:0] ST_EMPTY      = 3'd6;

  typedef struct packed {
    logic [7:0] sig_byte;
    logic       sig_last;
    logic [2:0] status;
  } dcse_result_t;

endpackage

// ----- hdl/dcse_parser.sv -----
// Front end: accepts certificate bytes, walks the DER header and element
// structure and produces result records. Depends on dcse_pkg.
`timescale 1ns / 1ps

module dcse_parser
  import dcse_pkg::*;
#(
  parameter int MAX_CERT_BYTES    = DEF_MAX_CERT_BYTES,
  parameter int MAX_LENGTH_OCTETS = DEF_MAX_LENGTH_OCTETS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [SIG_LIMIT_W-1:0] cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output logic                   push,
  output dcse_result_t           push_data
);

  localparam int RW = 8 * MAX_LENGTH_OCTETS;
  localparam int LW = $clog2(MAX_LENGTH_OCTETS + 1);
  localparam int CW = $clog2(MAX_CERT_BYTES + 2);
  localparam int XW = RW + SIG_LIMIT_W;

  localparam logic [2:0] PH_OUTER_TAG = 3'd0;
  localparam logic [2:0] PH_OUTER_LEN = 3'd1;
  localparam logic [2:0] PH_TBS_TAG   = 3'd2;
  localparam logic [2:0] PH_TBS_LEN   = 3'd3;
  localparam logic [2:0] PH_ELEM_TAG  = 3'd4;
  localparam logic [2:0] PH_ELEM_LEN  = 3'd5;
  localparam logic [2:0] PH_ELEM_BODY = 3'd6;
  localparam logic [2:0] PH_IDLE      = 3'd7;

  localparam logic [3:0] EL_VERSION    = 4'd0;
  localparam logic [3:0] EL_TBS_FIRST  = 4'd1;
  localparam logic [3:0] EL_KEY_INFO   = 4'd6;
  localparam logic [3:0] EL_EXTENSIONS = 4'd7;
  localparam logic [3:0] EL_SIG_ALG    = 4'd8;
  localparam logic [3:0] EL_SIG_VALUE  = 4'd9;

  localparam logic [1:0] LEN_MORE = 2'd0;
  localparam logic [1:0] LEN_DONE = 2'd1;
  localparam logic [1:0] LEN_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]    code;
    logic [RW-1:0] rem;
    logic [LW-1:0] left;
  } len_step_t;

  function automatic len_step_t take_len(input logic [7:0] b, input logic [RW-1:0] rem,
                                         input logic [LW-1:0] left);
    len_step_t  r;
    logic [6:0] n;
    logic [RW+7:0] sh;
    r.code = LEN_MORE;
    r.rem  = rem;
    r.left = left;
    n  = b[6:0] & LEN_COUNT_MASK;
    sh = {rem, b};
    if (left == '0) begin
      if ((b & LEN_LONG_FORM) != 8'h00) begin
        if (n > 7'(MAX_LENGTH_OCTETS)) begin
          r.code = LEN_BAD;
        end else begin
          r.rem = '0;
          if (n == 7'd0) begin
            r.code = LEN_DONE;
          end else begin
            r.left = n[LW-1:0];
          end
        end
      end else begin
        r.rem  = RW'(b);
        r.code = LEN_DONE;
      end
    end else begin
      r.rem  = sh[RW-1:0];
      r.left = left - 1'b1;
      r.code = (left == LW'(1)) ? LEN_DONE : LEN_MORE;
    end
    return r;
  endfunction

  logic [SIG_LIMIT_W-1:0] sig_limit;
  logic [2:0]             phase, phase_next;
  logic [3:0]             elem, elem_next;
  logic [RW-1:0]          rem, rem_next;
  logic [LW-1:0]          left, left_next;
  logic [CW-1:0]          count, count_next;
  logic [1:0]             voff, voff_next;
  logic                   has_ext, has_ext_next;
  logic                   first_sig, first_sig_next;
  logic [2:0]             err;
  logic                   data, data_last;
  logic                   in_fire;
  len_step_t              ls;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_limit <= SIG_LIMIT_RESET;
    end else if (cfg_valid) begin
      sig_limit <= cfg_data;
    end
  end

  always_comb begin
    phase_next     = phase;
    elem_next      = elem;
    rem_next       = rem;
    left_next      = left;
    count_next     = count;
    voff_next      = voff;
    has_ext_next   = has_ext;
    first_sig_next = first_sig;
    err            = ST_DATA;
    data           = 1'b0;
    data_last      = 1'b0;
    ls             = take_len(in_byte, rem, left);
    if (phase != PH_IDLE) begin
      count_next = count + 1'b1;
      if (count_next > CW'(MAX_CERT_BYTES)) begin
        err = ST_TOO_LARGE;
      end else begin
        unique case (phase)
          PH_OUTER_TAG: begin
            if (in_byte != TAG_SEQUENCE) begin
              err = ST_NOT_DER;
            end else begin
              phase_next = PH_OUTER_LEN;
            end
          end
          PH_OUTER_LEN, PH_TBS_LEN: begin
            rem_next  = ls.rem;
            left_next = ls.left;
            if (ls.code == LEN_BAD) begin
              err = ST_BAD_LENGTH;
            end else if (ls.code == LEN_DONE) begin
              phase_next = (phase == PH_OUTER_LEN) ? PH_TBS_TAG : PH_ELEM_TAG;
            end
          end
          PH_TBS_TAG: begin
            phase_next = PH_TBS_LEN;
          end
          PH_ELEM_TAG: begin
            if (elem == EL_VERSION && (in_byte & TAG_VERSION_MASK) == 8'h00) begin
              elem_next = EL_TBS_FIRST;
            end
            phase_next = PH_ELEM_LEN;
          end
          PH_ELEM_LEN: begin
            rem_next  = ls.rem;
            left_next = ls.left;
            if (ls.code == LEN_BAD) begin
              err = ST_BAD_LENGTH;
            end else if (ls.code == LEN_DONE) begin
              if (elem == EL_SIG_VALUE) begin
                if (ls.rem == '0) begin
                  err = ST_EMPTY;
                end else if (XW'(ls.rem) > XW'(sig_limit)) begin
                  err = ST_SIG_LONG;
                end else begin
                  first_sig_next = 1'b1;
                  phase_next     = PH_ELEM_BODY;
                end
              end else if (ls.rem == '0) begin
                if (elem == EL_KEY_INFO) begin
                  elem_next = has_ext ? EL_EXTENSIONS : EL_SIG_ALG;
                end else begin
                  elem_next = elem + 1'b1;
                end
                phase_next = PH_ELEM_TAG;
              end else begin
                phase_next = PH_ELEM_BODY;
              end
            end
          end
          PH_ELEM_BODY: begin
            rem_next = rem - 1'b1;
            if (elem == EL_SIG_VALUE) begin
              first_sig_next = 1'b0;
              if (first_sig && in_byte == 8'h00) begin
                if (rem_next == '0) begin
                  err = ST_EMPTY;
                end
              end else begin
                data      = 1'b1;
                data_last = (rem_next == '0);
                if (data_last) begin
                  phase_next = PH_IDLE;
                end
              end
            end else begin
              if (elem == EL_VERSION) begin
                if (voff < 2'd2) begin
                  voff_next = voff + 1'b1;
                end else if (voff == 2'd2) begin
                  has_ext_next = (in_byte != 8'h00);
                  voff_next    = 2'd3;
                end
              end
              if (rem_next == '0) begin
                if (elem == EL_KEY_INFO) begin
                  elem_next = has_ext_next ? EL_EXTENSIONS : EL_SIG_ALG;
                end else begin
                  elem_next = elem + 1'b1;
                end
                phase_next = PH_ELEM_TAG;
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
      if (err == ST_DATA && in_last && phase_next != PH_IDLE) begin
        err  = ST_TRUNCATED;
        data = 1'b0;
      end
      if (err != ST_DATA) begin
        phase_next = PH_IDLE;
      end
    end
    if (in_last) begin
      phase_next     = PH_OUTER_TAG;
      elem_next      = EL_VERSION;
      rem_next       = '0;
      left_next      = '0;
      count_next     = '0;
      voff_next      = 2'd0;
      has_ext_next   = 1'b0;
      first_sig_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OUTER_TAG;
      elem      <= EL_VERSION;
      rem       <= '0;
      left      <= '0;
      count     <= '0;
      voff      <= 2'd0;
      has_ext   <= 1'b0;
      first_sig <= 1'b1;
    end else if (in_fire) begin
      phase     <= phase_next;
      elem      <= elem_next;
      rem       <= rem_next;
      left      <= left_next;
      count     <= count_next;
      voff      <= voff_next;
      has_ext   <= has_ext_next;
      first_sig <= first_sig_next;
    end
  end

  assign push               = in_fire && (err != ST_DATA || data);
  assign push_data.sig_byte = (err != ST_DATA) ? 8'h00 : in_byte;
  assign push_data.sig_last = (err != ST_DATA) ? 1'b1 : data_last;
  assign push_data.status   = err;

`ifndef ASSERT_OFF
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_IDLE) |-> !push)
    else $error("result produced while waiting for end of certificate");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_CERT_BYTES + 1))
    else $error("byte count ran past the size limit");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_last) |=> (phase == PH_OUTER_TAG && count == '0 && first_sig))
    else $error("parser did not rearm after final byte");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.status != ST_DATA) |-> (push_data.sig_last && push_data.sig_byte == 8'h00))
    else $error("error result without final mark");
`endif

endmodule

// ----- hdl/dcse_queue.sv -----
// Short result queue between the parser and the output stage.
// Depends on dcse_pkg for the result record type.
`timescale 1ns / 1ps

module dcse_queue
  import dcse_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dcse_result_t push_data,
  output logic         not_full,
  output logic         not_empty,
  input  logic         pop,
  output dcse_result_t pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  dcse_result_t  slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;

  assign not_full  = (fill != NW'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (not_full || pop))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("request popped from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= NW'(QUEUE_DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

// ----- hdl/dcse_emit.sv -----
// Back end: output register that drains the result queue onto the stream.
// Depends on dcse_pkg for the result record type.
`timescale 1ns / 1ps

module dcse_emit
  import dcse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  dcse_result_t q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output dcse_result_t out_data
);

  logic         valid;
  dcse_result_t hold;

  assign q_pop     = q_valid && (!valid || out_ready);
  assign out_valid = valid;
  assign out_data  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (q_pop) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold <= q_data;
    end
  end

endmodule

// ----- hdl/der_certificate_signature_extractor.sv -----
// Top level of the DER certificate signature extractor.
// Depends on dcse_pkg, dcse_parser, dcse_queue and dcse_emit.
`timescale 1ns / 1ps

// Feed a DER X.509 certificate one byte per request on the slave stream,
// tlast on its final byte. The block takes one byte every clock cycle: the
// parser updates its header and length state once for each accepted byte,
// and its results go through a small queue and an output register, so input
// stalls only when the queue fills under output backpressure. The signature
// value bytes come out on the master stream with tuser = 0 and tlast on the
// final one; an error gives one result with tdata = 0, tlast = 1 and the
// error code in tuser, and the rest of that certificate is dropped. The
// signature length limit is written on the cfg channel, always ready.

module der_certificate_signature_extractor
  import dcse_pkg::*;
#(
  parameter int MAX_CERT_BYTES    = DEF_MAX_CERT_BYTES,
  parameter int MAX_LENGTH_OCTETS = DEF_MAX_LENGTH_OCTETS,
  parameter int QUEUE_DEPTH       = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SIG_LIMIT_W-1:0] cfg_data,       // signature_limit
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // cert_byte
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // sig_byte
  output logic [2:0]             m_axis_tuser,   // status
  output logic                   m_axis_tlast
);

  logic         push, q_not_full, q_not_empty, q_pop;
  dcse_result_t push_data, q_data, out_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = q_not_full;

  dcse_parser #(
    .MAX_CERT_BYTES   (MAX_CERT_BYTES),
    .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (s_axis_tvalid),
    .in_ready (q_not_full),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .push     (push),
    .push_data(push_data)
  );

  dcse_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .not_full (q_not_full),
    .not_empty(q_not_empty),
    .pop      (q_pop),
    .pop_data (q_data)
  );

  dcse_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_data)
  );

  assign m_axis_tdata = out_data.sig_byte;
  assign m_axis_tlast = out_data.sig_last;
  assign m_axis_tuser = out_data.status;

endmodule
